FILE: hdl/key_press_classifier_defines.svh
// assertion macros for the key press classifier
// used by key_press_classifier.sv; expects clk and rst_n in scope
`ifndef KEY_PRESS_CLASSIFIER_DEFINES_SVH
`define KEY_PRESS_CLASSIFIER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define KPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define KPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/kpc_pkg.sv
// shared types and constants for the key press classifier
// no dependencies
package kpc_pkg;

    // default width of the phase counter
    localparam int COUNTER_BITS_DEF = 16;

    // key counts and widths
    localparam int NUM_SIDE_KEYS = 4;
    localparam int DEB_BITS      = 8;
    localparam int TIME_BITS     = 16;
    localparam int CODE_BITS     = 3;
    localparam int CFG_IDX_BITS  = 2;

    // configuration reset values
    localparam logic [DEB_BITS-1:0]  DEBOUNCE_RST = 8'd1;
    localparam logic [TIME_BITS-1:0] LONG_RST     = 16'd70;
    localparam logic [TIME_BITS-1:0] GAP_RST      = 16'd40;

    // code values
    localparam logic [CODE_BITS-1:0] CODE_NONE   = 3'd0;
    localparam logic [CODE_BITS-1:0] CODE_LONG   = 3'd5;
    localparam logic [CODE_BITS-1:0] CODE_DOUBLE = 3'd6;

    // configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_DEBOUNCE = 2'd0,
        CFG_LONG     = 2'd1,
        CFG_GAP      = 2'd2
    } cfg_idx_t;

    // phases of key 0
    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_HOLD = 4'b0010,
        PH_GAP  = 4'b0100,
        PH_WAIT = 4'b1000
    } phase_t;

endpackage

FILE: hdl/key_press_classifier.sv
// key press classifier top level: debounce, long press, double click, key scan
// depends on kpc_pkg and key_press_classifier_defines.svh
//
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_stall  | key_levels
// out     | output    | out_valid / out_stall| key_code, reset_request, code_updated
// cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// one item per cycle while in_stall is low; each item's result appears in the
// cycle after it is taken. the single result register sets the latency: all
// classification logic sits between the state registers and that register.
// reset clears all state, config returns to 1 / 70 / 40.
// in_stall rises only while a result is held and out_stall is high.
`include "key_press_classifier_defines.svh"

module key_press_classifier #(
    parameter int COUNTER_BITS = kpc_pkg::COUNTER_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [kpc_pkg::NUM_SIDE_KEYS:0]    key_levels,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [kpc_pkg::CODE_BITS-1:0]      key_code,
    output logic                               reset_request,
    output logic                               code_updated,
    input  logic                               cfg_we,
    input  logic [kpc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [kpc_pkg::TIME_BITS-1:0]      cfg_data
);

    localparam int NK = kpc_pkg::NUM_SIDE_KEYS;
    localparam int DB = kpc_pkg::DEB_BITS;
    localparam int TB = kpc_pkg::TIME_BITS;
    localparam int CB = kpc_pkg::CODE_BITS;
    // compare width covering both counter and thresholds
    localparam int CW = (COUNTER_BITS > TB) ? COUNTER_BITS : TB;

    // configuration registers
    logic [DB-1:0] deb_reg;
    logic [TB-1:0] long_reg;
    logic [TB-1:0] gap_reg;

    // classifier state
    kpc_pkg::phase_t          phase_reg, phase_next;
    logic [COUNTER_BITS-1:0]  cnt_reg, cnt_next;
    logic [CB-1:0]            code_reg, code_next;
    logic [DB-1:0]            key_cnt_reg [NK];
    logic [DB-1:0]            key_cnt_next [NK];
    logic [DB-1:0]            prim_cnt_reg, prim_cnt_next;

    // result register
    logic out_valid_reg;
    logic reset_req_reg, reset_req_next;
    logic updated_reg, updated_next;

    logic                    accept;
    logic                    k0;
    logic [NK-1:0]           side_pressed;
    logic                    prim_pressed;
    logic [COUNTER_BITS-1:0] cnt_inc;
    logic [TB-1:0]           long_thr;
    logic [TB-1:0]           gap_thr;
    logic                    long_hit;
    logic                    gap_hit;

    assign accept   = in_valid && !in_stall;
    assign in_stall = out_valid_reg && out_stall;
    assign k0       = key_levels[0];

    // side key debouncers run on every item
    always_comb
    begin
        for (int i = 0; i < NK; i++)
        begin
            side_pressed[i] = key_levels[i+1] && (key_cnt_reg[i] >= deb_reg);
            if (!key_levels[i+1])
            begin
                key_cnt_next[i] = '0;
            end
            else if (key_cnt_reg[i] == '1)
            begin
                key_cnt_next[i] = key_cnt_reg[i];
            end
            else
            begin
                key_cnt_next[i] = key_cnt_reg[i] + 1'b1;
            end
        end
    end

    // key 0 debounce check
    assign prim_pressed = k0 && (prim_cnt_reg >= deb_reg);

    // saturating phase counter and thresholds (zero acts as one)
    assign cnt_inc  = (cnt_reg == '1) ? cnt_reg : cnt_reg + 1'b1;
    assign long_thr = (long_reg == '0) ? TB'(1) : long_reg;
    assign gap_thr  = (gap_reg == '0) ? TB'(1) : gap_reg;
    assign long_hit = CW'(cnt_inc) >= CW'(long_thr);
    assign gap_hit  = CW'(cnt_inc) >= CW'(gap_thr);

    // phase machine of key 0 and side key scan
    always_comb
    begin
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        code_next      = code_reg;
        prim_cnt_next  = prim_cnt_reg;
        reset_req_next = 1'b0;
        updated_next   = 1'b0;
        case (phase_reg)
            kpc_pkg::PH_HOLD:
            begin
                if (k0)
                begin
                    cnt_next = cnt_inc;
                    if (long_hit)
                    begin
                        code_next      = kpc_pkg::CODE_LONG;
                        reset_req_next = 1'b1;
                        updated_next   = 1'b1;
                        phase_next     = kpc_pkg::PH_IDLE;
                        cnt_next       = '0;
                    end
                end
                else
                begin
                    phase_next = kpc_pkg::PH_GAP;
                    cnt_next   = '0;
                end
            end
            kpc_pkg::PH_GAP:
            begin
                if (k0)
                begin
                    code_next    = kpc_pkg::CODE_DOUBLE;
                    updated_next = 1'b1;
                    phase_next   = kpc_pkg::PH_WAIT;
                    cnt_next     = '0;
                end
                else
                begin
                    cnt_next = cnt_inc;
                    if (gap_hit)
                    begin
                        code_next    = kpc_pkg::CODE_NONE;
                        updated_next = 1'b1;
                        phase_next   = kpc_pkg::PH_IDLE;
                        cnt_next     = '0;
                    end
                end
            end
            kpc_pkg::PH_WAIT:
            begin
                if (!k0)
                begin
                    phase_next = kpc_pkg::PH_IDLE;
                    cnt_next   = '0;
                end
            end
            default:
            begin
                phase_next = kpc_pkg::PH_IDLE;
                // key 0 debounce counter only runs while idle
                if (!k0)
                begin
                    prim_cnt_next = '0;
                end
                else if (prim_cnt_reg != '1)
                begin
                    prim_cnt_next = prim_cnt_reg + 1'b1;
                end
                if (prim_pressed)
                begin
                    phase_next    = kpc_pkg::PH_HOLD;
                    cnt_next      = '0;
                    prim_cnt_next = '0;
                end
                else
                begin
                    // highest pressed side key wins
                    for (int i = 0; i < NK; i++)
                    begin
                        if (side_pressed[i])
                        begin
                            code_next    = CB'(i + 1);
                            updated_next = 1'b1;
                        end
                    end
                end
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deb_reg  <= kpc_pkg::DEBOUNCE_RST;
            long_reg <= kpc_pkg::LONG_RST;
            gap_reg  <= kpc_pkg::GAP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                kpc_pkg::CFG_DEBOUNCE: deb_reg  <= cfg_data[DB-1:0];
                kpc_pkg::CFG_LONG:     long_reg <= cfg_data;
                kpc_pkg::CFG_GAP:      gap_reg  <= cfg_data;
                default:               ;
            endcase
        end
    end

    // state update on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= kpc_pkg::PH_IDLE;
            cnt_reg      <= '0;
            code_reg     <= kpc_pkg::CODE_NONE;
            prim_cnt_reg <= '0;
            for (int i = 0; i < NK; i++)
            begin
                key_cnt_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            cnt_reg      <= cnt_next;
            code_reg     <= code_next;
            prim_cnt_reg <= prim_cnt_next;
            for (int i = 0; i < NK; i++)
            begin
                key_cnt_reg[i] <= key_cnt_next[i];
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            reset_req_reg <= 1'b0;
            updated_reg   <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
            reset_req_reg <= reset_req_next;
            updated_reg   <= updated_next;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign key_code      = code_reg;
    assign reset_request = reset_req_reg;
    assign code_updated  = updated_reg;

    // checks
    `KPC_ASSERT_NOW(a_long_press_code, out_valid_reg && reset_req_reg, (code_reg == kpc_pkg::CODE_LONG) && updated_reg, "reset request without long press code")
    `KPC_ASSERT_NEXT(a_accept_gives_result, accept, out_valid_reg, "accepted item produced no result")
    `KPC_ASSERT_NOW(a_prim_cnt_idle_only, phase_reg != kpc_pkg::PH_IDLE, prim_cnt_reg == '0, "key 0 debounce count nonzero while classifying")

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// testbench for key_press_classifier: a directed key table, then random key bursts
// under several register settings, results checked against the table or a predictor
// depends on kpc_pkg and the key_press_classifier rtl
module testbench;
    import kpc_pkg::*;

    localparam int MAX_CYCLES  = 1000000;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_PCT    = 21;

    // side key codes used in the directed table
    localparam logic [CODE_BITS-1:0] CODE_KEY1 = 3'd1;
    localparam logic [CODE_BITS-1:0] CODE_KEY4 = 3'd4;

    typedef struct packed {
        logic [CODE_BITS-1:0] code;
        logic                 rr;
        logic                 upd;
    } outcome_t;

    typedef struct packed {
        logic [NUM_SIDE_KEYS:0] lv;
        logic [19:0]            reps;
        logic                   typed;
        outcome_t               want;
    } row_t;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic [NUM_SIDE_KEYS:0]    key_levels;
    logic                      out_valid;
    logic                      out_stall;
    logic [CODE_BITS-1:0]      key_code;
    logic                      reset_request;
    logic                      code_updated;
    logic                      cfg_we;
    cfg_idx_t                  cfg_index;
    logic [TIME_BITS-1:0]      cfg_data;

    // predictor state and register copies
    phase_t                    pr_phase;
    logic [15:0]               pr_count;
    logic [CODE_BITS-1:0]      pr_code;
    logic [DEB_BITS-1:0]       side_deb [NUM_SIDE_KEYS];
    logic [DEB_BITS-1:0]       key0_deb;
    logic [DEB_BITS-1:0]       deb_cfg;
    logic [TIME_BITS-1:0]      long_cfg;
    logic [TIME_BITS-1:0]      gap_cfg;

    outcome_t                  pending_codes [$];
    row_t                      plan [0:19];
    int                        errors;
    int                        items_sent;
    int                        results_seen;
    int                        cycles;
    bit                        send_idle;
    bit                        recv_idle;
    bit                        hold_req;

    key_press_classifier DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .key_levels    (key_levels),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .key_code      (key_code),
        .reset_request (reset_request),
        .code_updated  (code_updated),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // one debouncer step: returns {pressed, next count}
    function automatic logic [DEB_BITS:0] debounce_tick(input logic [DEB_BITS-1:0] cnt,
                                                        input logic lvl);
        logic hit;
        hit = 1'b0;
        if (lvl)
        begin
            hit = (cnt >= deb_cfg);
            if (cnt != 8'hFF)
                cnt = cnt + 8'd1;
        end
        else
            cnt = 8'd0;
        return {hit, cnt};
    endfunction

    // advance the predictor by one tick of key levels
    function automatic outcome_t classify_tick(input logic [NUM_SIDE_KEYS:0] lv);
        outcome_t                 r;
        logic [DEB_BITS:0]        db;
        logic [NUM_SIDE_KEYS-1:0] hit;
        logic [TIME_BITS-1:0]     lp;
        logic [TIME_BITS-1:0]     gp;
        bit                       found;
        r = '0;
        found = 1'b0;
        lp = (long_cfg == 16'd0) ? 16'd1 : long_cfg;
        gp = (gap_cfg == 16'd0) ? 16'd1 : gap_cfg;
        for (int i = 0; i < NUM_SIDE_KEYS; i++)
        begin
            db = debounce_tick(side_deb[i], lv[i+1]);
            hit[i] = db[DEB_BITS];
            side_deb[i] = db[DEB_BITS-1:0];
        end
        case (pr_phase)
            PH_HOLD:
            begin
                if (lv[0])
                begin
                    if (pr_count != 16'hFFFF)
                        pr_count = pr_count + 16'd1;
                    // held long enough: long press
                    if (pr_count >= lp)
                    begin
                        pr_code = CODE_LONG;
                        r.rr = 1'b1;
                        r.upd = 1'b1;
                        pr_phase = PH_IDLE;
                        pr_count = 16'd0;
                    end
                end
                else
                begin
                    pr_phase = PH_GAP;
                    pr_count = 16'd0;
                end
            end
            PH_GAP:
            begin
                if (lv[0])
                begin
                    pr_code = CODE_DOUBLE;
                    r.upd = 1'b1;
                    pr_phase = PH_WAIT;
                    pr_count = 16'd0;
                end
                else
                begin
                    if (pr_count != 16'hFFFF)
                        pr_count = pr_count + 16'd1;
                    // no second press in the window: single press
                    if (pr_count >= gp)
                    begin
                        pr_code = CODE_NONE;
                        r.upd = 1'b1;
                        pr_phase = PH_IDLE;
                        pr_count = 16'd0;
                    end
                end
            end
            PH_WAIT:
            begin
                if (!lv[0])
                begin
                    pr_phase = PH_IDLE;
                    pr_count = 16'd0;
                end
            end
            default:
            begin
                pr_phase = PH_IDLE;
                db = debounce_tick(key0_deb, lv[0]);
                key0_deb = db[DEB_BITS-1:0];
                if (db[DEB_BITS])
                begin
                    pr_phase = PH_HOLD;
                    pr_count = 16'd0;
                    key0_deb = 8'd0;
                end
                else
                begin
                    // highest pressed side key wins
                    for (int i = NUM_SIDE_KEYS - 1; i >= 0; i--)
                    begin
                        if (hit[i] && !found)
                        begin
                            pr_code = i[2:0] + 3'd1;
                            r.upd = 1'b1;
                            found = 1'b1;
                        end
                    end
                end
            end
        endcase
        r.code = pr_code;
        return r;
    endfunction

    task log_mismatch(input string what);
        $display("mismatch at result %0d: %s", results_seen, what);
        errors++;
    endtask

    // offer one item, with random idle cycles ahead of it while send_idle is set
    task send_item(input logic [NUM_SIDE_KEYS:0] lv, input bit typed, input outcome_t want);
        outcome_t pred;
        while (send_idle && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        pred = classify_tick(lv);
        pending_codes.push_back(typed ? want : pred);
        in_valid <= 1'b1;
        key_levels <= lv;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // hold key 0 at one level for a number of ticks, side keys bouncing now and then
    task hold_keys(input bit k0, input int ticks, input logic [NUM_SIDE_KEYS-1:0] side);
        logic [NUM_SIDE_KEYS-1:0] s;
        int                       j;
        s = side;
        repeat (ticks)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                j = $urandom_range(0, NUM_SIDE_KEYS - 1);
                s[j] = ~s[j];
            end
            send_item({s, k0}, 1'b0, '0);
        end
    endtask

    // random key bursts: key 0 press sequences, side-key-only runs and some noise
    task random_bursts(input int n);
        int                       stop;
        int                       kind;
        int                       lp;
        int                       gp;
        int                       hold;
        logic [NUM_SIDE_KEYS-1:0] side;
        logic [NUM_SIDE_KEYS:0]   noise;
        stop = items_sent + n;
        lp = (long_cfg == 16'd0) ? 1 : long_cfg;
        gp = (gap_cfg == 16'd0) ? 1 : gap_cfg;
        while (items_sent < stop)
        begin
            kind = $urandom_range(0, 9);
            side = ($urandom_range(0, 1) != 0) ? 4'($urandom_range(0, 15)) : 4'd0;
            if (kind < 5)
            begin
                // key 0: released early, just short of, at or past the long-press time
                case ($urandom_range(0, 3))
                    0: hold = $urandom_range(0, lp - 1);
                    1: hold = lp - 1;
                    2: hold = lp;
                    default: hold = lp + $urandom_range(0, 3);
                endcase
                hold_keys(1'b1, deb_cfg + 1 + hold, side);
                hold_keys(1'b0, $urandom_range(1, gp + 2), side);
                if ($urandom_range(0, 1) != 0)
                begin
                    hold_keys(1'b1, $urandom_range(1, 4), side);
                    hold_keys(1'b0, $urandom_range(1, gp + 2), side);
                end
            end
            else if (kind < 8)
            begin
                // side keys only
                side = 4'($urandom_range(1, 15));
                hold_keys(1'b0, $urandom_range(1, deb_cfg + 4), side);
                hold_keys(1'b0, $urandom_range(0, 2), 4'd0);
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                begin
                    noise = 5'($urandom_range(0, 31));
                    send_item(noise, 1'b0, '0);
                end
            end
        end
    endtask

    // stop offering and wait for every expected result
    task settle();
        in_valid <= 1'b0;
        while (pending_codes.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task write_reg(input cfg_idx_t idx, input logic [TIME_BITS-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_DEBOUNCE: deb_cfg = value[DEB_BITS-1:0];
            CFG_LONG:     long_cfg = value;
            CFG_GAP:      gap_cfg = value;
            default:      ;
        endcase
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_stall <= recv_idle && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin : check_results
        outcome_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_codes.size() == 0)
                log_mismatch("result with nothing expected");
            else
            begin
                want = pending_codes.pop_front();
                if (key_code !== want.code)
                    log_mismatch($sformatf("key_code %0d, expected %0d", key_code, want.code));
                if (reset_request !== want.rr)
                    log_mismatch($sformatf("reset_request %0b, expected %0b",
                                           reset_request, want.rr));
                if (code_updated !== want.upd)
                    log_mismatch($sformatf("code_updated %0b, expected %0b",
                                           code_updated, want.upd));
            end
            results_seen++;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= MAX_CYCLES)
        begin
            $display("run timed out after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        key_levels <= '0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_DEBOUNCE;
        cfg_data <= '0;
        errors = 0;
        items_sent = 0;
        results_seen = 0;
        cycles = 0;
        send_idle = 1'b1;
        recv_idle = 1'b1;
        hold_req = 1'b0;
        pr_phase = PH_IDLE;
        pr_count = 16'd0;
        pr_code = CODE_NONE;
        key0_deb = 8'd0;
        for (int i = 0; i < NUM_SIDE_KEYS; i++)
            side_deb[i] = 8'd0;
        deb_cfg = DEBOUNCE_RST;
        long_cfg = LONG_RST;
        gap_cfg = GAP_RST;

        // directed table at reset settings: levels, repeats, typed, expected
        plan = '{
            {5'b00000, 20'd1,   1'b1, CODE_NONE,   1'b0, 1'b0},
            {5'b11110, 20'd1,   1'b1, CODE_NONE,   1'b0, 1'b0},
            {5'b11110, 20'd1,   1'b1, CODE_KEY4,   1'b0, 1'b1},
            {5'b00010, 20'd1,   1'b1, CODE_KEY1,   1'b0, 1'b1},
            {5'b00000, 20'd1,   1'b1, CODE_KEY1,   1'b0, 1'b0},
            {5'b00001, 20'd1,   1'b1, CODE_KEY1,   1'b0, 1'b0},
            {5'b00001, 20'd1,   1'b1, CODE_KEY1,   1'b0, 1'b0},
            {5'b11111, 20'd3,   1'b0, CODE_NONE,   1'b0, 1'b0},
            {5'b00000, 20'd1,   1'b0, CODE_NONE,   1'b0, 1'b0},
            {5'b00001, 20'd1,   1'b1, CODE_DOUBLE, 1'b0, 1'b1},
            {5'b11101, 20'd4,   1'b0, CODE_NONE,   1'b0, 1'b0},
            {5'b11100, 20'd1,   1'b0, CODE_NONE,   1'b0, 1'b0},
            {5'b11100, 20'd1,   1'b0, CODE_NONE,   1'b0, 1'b0},
            {5'b00001, 20'd2,   1'b0, CODE_NONE,   1'b0, 1'b0},
            {5'b00001, 20'd70,  1'b0, CODE_NONE,   1'b0, 1'b0},
            {5'b00001, 20'd2,   1'b0, CODE_NONE,   1'b0, 1'b0},
            {5'b00000, 20'd41,  1'b0, CODE_NONE,   1'b0, 1'b0},
            {5'b10100, 20'd300, 1'b0, CODE_NONE,   1'b0, 1'b0},
            {5'b01010, 20'd1,   1'b0, CODE_NONE,   1'b0, 1'b0},
            {5'b11011, 20'd2,   1'b0, CODE_NONE,   1'b0, 1'b0}
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < 20; r++)
            repeat (plan[r].reps) send_item(plan[r].lv, plan[r].typed, plan[r].want);

        // random at reset settings
        random_bursts(120);
        settle();

        // shortest times, upper bits of the debounce write set
        write_reg(CFG_DEBOUNCE, 16'hFF00);
        write_reg(CFG_LONG, 16'd1);
        write_reg(CFG_GAP, 16'd1);
        random_bursts(80);
        settle();

        // zero times behave as one
        write_reg(CFG_DEBOUNCE, 16'h3C00);
        write_reg(CFG_LONG, 16'd0);
        write_reg(CFG_GAP, 16'd0);
        random_bursts(80);
        settle();

        // moderate times, no idling on either side
        send_idle = 1'b0;
        recv_idle = 1'b0;
        write_reg(CFG_DEBOUNCE, 16'h0003);
        write_reg(CFG_LONG, 16'd12);
        write_reg(CFG_GAP, 16'd8);
        random_bursts(120);
        // release everything so key 0 is back to idle
        repeat (12) send_item(5'b00000, 1'b0, '0);
        settle();
        send_idle = 1'b1;
        recv_idle = 1'b1;

        // longest debounce with short press times
        write_reg(CFG_DEBOUNCE, 16'h00FF);
        write_reg(CFG_LONG, 16'd6);
        write_reg(CFG_GAP, 16'd4);
        random_bursts(100);
        settle();

        write_reg(CFG_DEBOUNCE, 16'hC302);
        write_reg(CFG_LONG, 16'd20);
        write_reg(CFG_GAP, 16'd15);
        random_bursts(80);
        settle();

        // receiver holds off for a while so the block backs up
        write_reg(CFG_DEBOUNCE, 16'h0001);
        write_reg(CFG_LONG, 16'd4);
        write_reg(CFG_GAP, 16'd6);
        hold_req = 1'b1;
        random_bursts(120);
        settle();

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
